// ===== rtl/mdjpf_pkg.sv =====
// shared types and constants of the max dijet mass pair finder
`timescale 1ns / 1ps
`default_nettype none
package mdjpf_pkg;

  // field widths
  localparam int PtW     = 16;
  localparam int EtaW    = 11;
  localparam int EtaMaxW = 10;
  localparam int EnergyW = 16;
  localparam int MomW    = 16;
  localparam int IndexW  = 4;
  localparam int MassW   = 34;
  localparam int CfgDataW = 16;
  localparam int CfgIdxW  = 1;

  // one stored jet: energy, px, py, pz
  localparam int JetW = EnergyW + 3 * MomW;

  localparam int MaxJetsDefault = 16;

  localparam logic [PtW-1:0]     PtMinReset  = '0;
  localparam logic [EtaMaxW-1:0] EtaMaxReset = 10'd640;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PT_MIN  = 1'b0,
    CFG_ETA_MAX = 1'b1
  } cfg_idx_e;

  // controller to datapath
  typedef struct packed {
    logic accept;  // input transaction taken this cycle
    logic issue;   // read one stored jet and pair it
    logic emit;    // load result register and clear the event
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic jet_pairs;   // offered jet passes, is in range and has partners
    logic jet_last;    // offered jet ends the event
    logic issue_last;  // current issue reads the last partner
    logic pipe_empty;  // no pair left in the mass pipeline
    logic out_free;    // result register can take a new result
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/mdjpf_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module mdjpf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/mdjpf_ctrl.sv =====
// controller state machine of the max dijet mass pair finder
`timescale 1ns / 1ps
`default_nettype none
module mdjpf_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output      logic                   in_stall_o,
  output      mdjpf_pkg::dp_cmd_t     cmd_o,
  input  wire mdjpf_pkg::dp_status_t  status_i
);
  import mdjpf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_EMIT
  } state_e;

  state_e state_q;
  logic   last_q;
  logic   stall_q;
  logic   accept;

  assign accept     = in_valid_i && !stall_q;
  assign in_stall_o = stall_q;

  assign cmd_o.accept = accept;
  assign cmd_o.issue  = (state_q == S_ISSUE);
  assign cmd_o.emit   = (state_q == S_EMIT) && status_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      last_q  <= 1'b0;
      stall_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            last_q <= status_i.jet_last;
            if (status_i.jet_pairs) begin
              state_q <= S_ISSUE;
              stall_q <= 1'b1;
            end else if (status_i.jet_last) begin
              state_q <= S_EMIT;
              stall_q <= 1'b1;
            end
          end
        end
        S_ISSUE: begin
          if (status_i.issue_last) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (status_i.pipe_empty) begin
            if (last_q) begin
              state_q <= S_EMIT;
            end else begin
              state_q <= S_IDLE;
              stall_q <= 1'b0;
            end
          end
        end
        S_EMIT: begin
          if (status_i.out_free) begin
            state_q <= S_IDLE;
            stall_q <= 1'b0;
          end
        end
        default: begin
          state_q <= S_IDLE;
          stall_q <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mdjpf_dpath.sv =====
// datapath of the max dijet mass pair finder: jet store, mass pipeline, best pair
`timescale 1ns / 1ps
`default_nettype none
module mdjpf_dpath #(
  parameter int MaxJets = mdjpf_pkg::MaxJetsDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire mdjpf_pkg::cfg_idx_e               cfg_idx_i,
  input  wire logic [mdjpf_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  wire logic [mdjpf_pkg::PtW-1:0]         jet_pt_i,
  input  wire logic signed [mdjpf_pkg::EtaW-1:0] jet_eta_i,
  input  wire logic [mdjpf_pkg::EnergyW-1:0]     jet_energy_i,
  input  wire logic signed [mdjpf_pkg::MomW-1:0] jet_px_i,
  input  wire logic signed [mdjpf_pkg::MomW-1:0] jet_py_i,
  input  wire logic signed [mdjpf_pkg::MomW-1:0] jet_pz_i,
  input  wire logic                              last_jet_i,
  input  wire mdjpf_pkg::dp_cmd_t                cmd_i,
  output      mdjpf_pkg::dp_status_t             status_o,
  input  wire logic                              out_stall_i,
  output      logic                              out_valid_o,
  output      logic                              pair_found_o,
  output      logic [mdjpf_pkg::IndexW-1:0]      first_index_o,
  output      logic [mdjpf_pkg::IndexW-1:0]      second_index_o,
  output      logic [mdjpf_pkg::MassW-1:0]       mass_squared_o,
  output      logic                              jets_dropped_o
);
  import mdjpf_pkg::*;

  localparam int AddrW = $clog2(MaxJets);
  localparam int CntW  = $clog2(MaxJets + 1);
  localparam int WordW = AddrW + JetW;
  localparam int SumW  = MomW + 1;
  localparam int SqW   = 2 * SumW;
  localparam int M2W   = SqW + 2;

  // configuration registers
  logic [PtW-1:0]     pt_min_q;
  logic [EtaMaxW-1:0] eta_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_min_q  <= PtMinReset;
      eta_max_q <= EtaMaxReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PT_MIN:  pt_min_q  <= cfg_wdata_i[PtW-1:0];
        CFG_ETA_MAX: eta_max_q <= cfg_wdata_i[EtaMaxW-1:0];
      endcase
    end
  end

  // event state
  logic [CntW-1:0]  seen_q, stored_q, pairs_q, k_q;
  logic             dropped_q;
  logic [MassW-1:0] best_mass_q;
  logic [AddrW-1:0] best_first_q, best_second_q;

  // jet selection on the offered item
  logic [EtaW-1:0] abs_eta;
  logic            jet_pass, in_range, store_en;

  assign abs_eta  = jet_eta_i[EtaW-1] ? EtaW'(-jet_eta_i) : EtaW'(jet_eta_i);
  assign jet_pass = (jet_pt_i >= pt_min_q) && (abs_eta <= {1'b0, eta_max_q});
  assign in_range = (seen_q < CntW'(MaxJets));
  assign store_en = cmd_i.accept && in_range && jet_pass;

  // current jet held while it is paired against the store
  logic [EnergyW-1:0]     cur_e_q;
  logic signed [MomW-1:0] cur_px_q, cur_py_q, cur_pz_q;
  logic [AddrW-1:0]       cur_pos_q;

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      cur_e_q   <= jet_energy_i;
      cur_px_q  <= jet_px_i;
      cur_py_q  <= jet_py_i;
      cur_pz_q  <= jet_pz_i;
      cur_pos_q <= seen_q[AddrW-1:0];
    end
  end

  // jet store
  logic [WordW-1:0] wr_word, rd_word;

  assign wr_word = {seen_q[AddrW-1:0], jet_energy_i, jet_px_i, jet_py_i, jet_pz_i};

  mdjpf_ram #(
    .Width (WordW),
    .Depth (MaxJets)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_en),
    .waddr_i (stored_q[AddrW-1:0]),
    .wdata_i (wr_word),
    .re_i    (cmd_i.issue),
    .raddr_i (k_q[AddrW-1:0]),
    .rdata_o (rd_word)
  );

  logic [AddrW-1:0]       rd_pos;
  logic [EnergyW-1:0]     rd_e;
  logic signed [MomW-1:0] rd_px, rd_py, rd_pz;

  assign {rd_pos, rd_e, rd_px, rd_py, rd_pz} = rd_word;

  // mass pipeline: read, sums, squares, difference, compare
  logic                   rd_v_q, sum_v_q, sq_v_q, m2_v_q;
  logic [SumW-1:0]        e_sum_q;
  logic signed [SumW-1:0] x_sum_q, y_sum_q, z_sum_q;
  logic [SqW-1:0]         e2_q;
  logic signed [SqW-1:0]  x2_q, y2_q, z2_q;
  logic signed [M2W-1:0]  m2_q;
  logic [AddrW-1:0]       ip_sum_q, ip_sq_q, ip_m2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q  <= 1'b0;
      sum_v_q <= 1'b0;
      sq_v_q  <= 1'b0;
      m2_v_q  <= 1'b0;
    end else begin
      rd_v_q  <= cmd_i.issue;
      sum_v_q <= rd_v_q;
      sq_v_q  <= sum_v_q;
      m2_v_q  <= sq_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e_sum_q  <= SumW'(rd_e) + SumW'(cur_e_q);
    x_sum_q  <= SumW'(rd_px) + SumW'(cur_px_q);
    y_sum_q  <= SumW'(rd_py) + SumW'(cur_py_q);
    z_sum_q  <= SumW'(rd_pz) + SumW'(cur_pz_q);
    ip_sum_q <= rd_pos;

    e2_q    <= e_sum_q * e_sum_q;
    x2_q    <= x_sum_q * x_sum_q;
    y2_q    <= y_sum_q * y_sum_q;
    z2_q    <= z_sum_q * z_sum_q;
    ip_sq_q <= ip_sum_q;

    m2_q    <= $signed({2'b00, e2_q}) - M2W'(x2_q) - M2W'(y2_q) - M2W'(z2_q);
    ip_m2_q <= ip_sq_q;
  end

  // strictly positive and better, earlier first jet wins a tie
  logic m2_pos, m2_better;

  assign m2_pos    = !m2_q[M2W-1] && (m2_q != '0);
  assign m2_better = m2_pos &&
                     ((m2_q[MassW-1:0] > best_mass_q) ||
                      ((m2_q[MassW-1:0] == best_mass_q) && (ip_m2_q < best_first_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q        <= '0;
      stored_q      <= '0;
      pairs_q       <= '0;
      k_q           <= '0;
      dropped_q     <= 1'b0;
      best_mass_q   <= '0;
      best_first_q  <= '0;
      best_second_q <= '0;
    end else if (cmd_i.emit) begin
      seen_q        <= '0;
      stored_q      <= '0;
      dropped_q     <= 1'b0;
      best_mass_q   <= '0;
      best_first_q  <= '0;
      best_second_q <= '0;
    end else begin
      if (cmd_i.accept) begin
        k_q     <= '0;
        pairs_q <= stored_q;
        if (in_range) begin
          seen_q <= seen_q + CntW'(1);
        end else begin
          dropped_q <= 1'b1;
        end
      end
      if (store_en) begin
        stored_q <= stored_q + CntW'(1);
      end
      if (cmd_i.issue) begin
        k_q <= k_q + CntW'(1);
      end
      if (m2_v_q && m2_better) begin
        best_mass_q   <= m2_q[MassW-1:0];
        best_first_q  <= ip_m2_q;
        best_second_q <= cur_pos_q;
      end
    end
  end

  // result register
  logic             out_valid_q, found_q, dropped_out_q;
  logic [IndexW-1:0] first_q, second_q;
  logic [MassW-1:0] mass_q;
  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // indices stay zero while no pair has been found
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      found_q       <= (best_mass_q != '0);
      first_q       <= IndexW'(best_first_q);
      second_q      <= IndexW'(best_second_q);
      mass_q        <= best_mass_q;
      dropped_out_q <= dropped_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pair_found_o   = found_q;
  assign first_index_o  = first_q;
  assign second_index_o = second_q;
  assign mass_squared_o = mass_q;
  assign jets_dropped_o = dropped_out_q;

  assign status_o.jet_pairs  = in_range && jet_pass && (stored_q != '0);
  assign status_o.jet_last   = last_jet_i;
  assign status_o.issue_last = ((k_q + CntW'(1)) == pairs_q);
  assign status_o.pipe_empty = !(rd_v_q || sum_v_q || sq_v_q || m2_v_q);
  assign status_o.out_free   = out_free;

endmodule
`default_nettype wire

// ===== rtl/max_dijet_mass_pair_finder.sv =====
// top level of the max dijet mass pair finder
//
// usage: jets of one event arrive one per input transaction on the valid and
// stall channel (pt, eta, energy, px, py, pz, last_jet). a jet passes when
// pt >= pt_min and |eta| <= eta_max; each passing jet is paired against every
// earlier passing jet of the event and the pair of largest positive mass
// squared is kept. the jet with last_jet set closes the event: one result
// transaction (pair_found, both indices, mass_squared, jets_dropped) follows
// and the event state is cleared. jets past MAX_JETS are ignored and flagged.
// pairing: a passing jet with stored partners holds the input until its
// partners, one per cycle through the jet store read port, have drained from
// a four stage mass pipeline; any other jet stalls the input only when it
// closes the event. the last jet holds the input until the result register
// is loaded. pt_min and eta_max are written on the cfg port between events.
// reset: clears the event, pt_min to 0 and eta_max to 640; the jet store is
// not cleared, only entries written in the current event are read.
// a stalled result is held in the output register while the next event's
// jets are accepted; only the closing of the next event waits for it.
`timescale 1ns / 1ps
`default_nettype none
module max_dijet_mass_pair_finder #(
  parameter int MAX_JETS = mdjpf_pkg::MaxJetsDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write port
  input  wire logic                              cfg_we_i,
  input  wire mdjpf_pkg::cfg_idx_e               cfg_idx_i,
  input  wire logic [mdjpf_pkg::CfgDataW-1:0]    cfg_wdata_i,
  // jet input channel
  input  wire logic                              in_valid_i,
  output      logic                              in_stall_o,
  input  wire logic [mdjpf_pkg::PtW-1:0]         jet_pt_i,
  input  wire logic signed [mdjpf_pkg::EtaW-1:0] jet_eta_i,
  input  wire logic [mdjpf_pkg::EnergyW-1:0]     jet_energy_i,
  input  wire logic signed [mdjpf_pkg::MomW-1:0] jet_px_i,
  input  wire logic signed [mdjpf_pkg::MomW-1:0] jet_py_i,
  input  wire logic signed [mdjpf_pkg::MomW-1:0] jet_pz_i,
  input  wire logic                              last_jet_i,
  // result channel
  output      logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  output      logic                              pair_found_o,
  output      logic [mdjpf_pkg::IndexW-1:0]      first_index_o,
  output      logic [mdjpf_pkg::IndexW-1:0]      second_index_o,
  output      logic [mdjpf_pkg::MassW-1:0]       mass_squared_o,
  output      logic                              jets_dropped_o
);
  import mdjpf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencing: accept, partner issue, pipeline drain, result load
  mdjpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  // jet store, mass pipeline, best pair tracking and result register
  mdjpf_dpath #(
    .MaxJets (MAX_JETS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .jet_pt_i       (jet_pt_i),
    .jet_eta_i      (jet_eta_i),
    .jet_energy_i   (jet_energy_i),
    .jet_px_i       (jet_px_i),
    .jet_py_i       (jet_py_i),
    .jet_pz_i       (jet_pz_i),
    .last_jet_i     (last_jet_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .pair_found_o   (pair_found_o),
    .first_index_o  (first_index_o),
    .second_index_o (second_index_o),
    .mass_squared_o (mass_squared_o),
    .jets_dropped_o (jets_dropped_o)
  );

endmodule
`default_nettype wire

// ===== rtl/mdjpf_checker.sv =====
// port level checker of the max dijet mass pair finder and its bind
`timescale 1ns / 1ps
`default_nettype none
module mdjpf_checker (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire mdjpf_pkg::cfg_idx_e               cfg_idx_i,
  input  wire logic [mdjpf_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  wire logic                              in_valid_i,
  input  wire logic                              in_stall_o,
  input  wire logic [mdjpf_pkg::PtW-1:0]         jet_pt_i,
  input  wire logic signed [mdjpf_pkg::EtaW-1:0] jet_eta_i,
  input  wire logic [mdjpf_pkg::EnergyW-1:0]     jet_energy_i,
  input  wire logic signed [mdjpf_pkg::MomW-1:0] jet_px_i,
  input  wire logic signed [mdjpf_pkg::MomW-1:0] jet_py_i,
  input  wire logic signed [mdjpf_pkg::MomW-1:0] jet_pz_i,
  input  wire logic                              last_jet_i,
  input  wire logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  input  wire logic                              pair_found_o,
  input  wire logic [mdjpf_pkg::IndexW-1:0]      first_index_o,
  input  wire logic [mdjpf_pkg::IndexW-1:0]      second_index_o,
  input  wire logic [mdjpf_pkg::MassW-1:0]       mass_squared_o,
  input  wire logic                              jets_dropped_o
);

  // a stalled result transaction stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result transaction dropped while stalled");

  // no pair means zero indices and zero mass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pair_found_o |->
      (first_index_o == '0) && (second_index_o == '0) && (mass_squared_o == '0))
    else $error("empty result carries a pair");

  // a found pair has positive mass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pair_found_o |-> (mass_squared_o != '0))
    else $error("found pair with zero mass");

  // the closing jet always makes the block busy while the result is built
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_jet_i |=> in_stall_o)
    else $error("input taken right after the closing jet");

endmodule

bind max_dijet_mass_pair_finder mdjpf_checker u_mdjpf_checker (.*);
`default_nettype wire
